// File: rtl/lpmd_pkg.sv
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared types and constants for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpmd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned Q_DEPTH  = 2;
    localparam int unsigned Q_PTR_W  = 1;
    localparam int unsigned Q_CNT_W  = 2;

    // Flag byte codes.
    localparam logic [BYTE_W-1:0] FLAG_PLAIN      = 8'd0;
    localparam logic [BYTE_W-1:0] FLAG_COMPRESSED = 8'd1;

    // One result on its way from the parser to the output register.
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              is_compressed;
        logic              last_of_message;
        logic              empty_message;
        logic              bad_flag;
    } t_result;

    // Queue fill status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: rtl/length_prefixed_message_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// Splits a byte stream of flag/length/payload frames into tagged payload bytes.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one stream byte per transfer (i_valid,
// o_stall, i_stream_byte). Each frame is a flag byte (0 plain, 1 compressed),
// a four-byte big-endian length and that many payload bytes. The output
// channel (o_valid, i_stall) carries one result per payload byte, tagged with
// the frame's compressed flag and a last mark on the final byte. A frame of
// length zero gives one result with empty_message set; a flag byte other
// than 0 or 1 gives one result with bad_flag set and is otherwise dropped.
// Header bytes give no result.
// Throughput is one byte per cycle in steady state, while o_stall is low.
// A result is written into the queue when its byte is accepted and from
// there into the output register, from which it leaves on the channel.
// When the receiver stalls, the output register holds its result and the
// two-entry queue absorbs up to two more results; once the queue is full
// o_stall rises and the parser stops. The parser stalls on nothing else.
// Reset (synchronous, active low) empties the queue and output register and
// returns the parser to waiting for a flag byte.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [lpmd_pkg::BYTE_W-1:0]    i_stream_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [lpmd_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic                           o_is_compressed,
    output logic                           o_last_of_message,
    output logic                           o_empty_message,
    output logic                           o_bad_flag
);

    lpmd_pkg::t_q_status  q_status;
    lpmd_pkg::t_result    push_data;
    lpmd_pkg::t_result    q_data;
    lpmd_pkg::t_result    out_result;
    logic                 push;
    logic                 pop;

    // Front part: header parsing and payload counting.
    lpmd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_stream_byte (i_stream_byte),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_result      (push_data)
    );

    // Short queue that lets the two sides stall independently.
    lpmd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (push_data),
        .i_pop     (pop),
        .o_rd_data (q_data),
        .o_status  (q_status)
    );

    // Back part: registered output channel.
    lpmd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_data   (q_data),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (out_result)
    );

    assign o_payload_byte    = out_result.payload_byte;
    assign o_is_compressed   = out_result.is_compressed;
    assign o_last_of_message = out_result.last_of_message;
    assign o_empty_message   = out_result.empty_message;
    assign o_bad_flag        = out_result.bad_flag;

endmodule

// File: rtl/lpmd_front.sv
// ----------------------------------------------------------------------------
// lpmd_front
// Byte parser: tracks the frame header, counts payload and classifies bytes.
// ----------------------------------------------------------------------------
module lpmd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lpmd_pkg::BYTE_W-1:0]         i_stream_byte,
    input  lpmd_pkg::t_q_status                 i_q_status,
    output logic                                o_push,
    output lpmd_pkg::t_result                   o_result
);

    typedef enum logic [2:0] {
        PH_FLAG,
        PH_LEN0,
        PH_LEN1,
        PH_LEN2,
        PH_LEN3,
        PH_DATA
    } t_phase;

    t_phase                        r_phase, n_phase;
    logic [lpmd_pkg::LEN_W-1:0]    r_len,   n_len;
    logic                          r_comp,  n_comp;
    logic                          accept;
    logic                          push;
    logic [lpmd_pkg::LEN_W-1:0]    len_full;
    lpmd_pkg::t_result             result;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_comp   = r_comp;
        push     = 1'b0;
        result   = '0;
        len_full = {r_len[lpmd_pkg::LEN_W-1:8], i_stream_byte};
        case (r_phase)
            PH_LEN0: begin
                n_len   = {i_stream_byte, 24'd0};
                n_phase = PH_LEN1;
            end
            PH_LEN1: begin
                n_len   = {r_len[31:24], i_stream_byte, 16'd0};
                n_phase = PH_LEN2;
            end
            PH_LEN2: begin
                n_len   = {r_len[31:16], i_stream_byte, 8'd0};
                n_phase = PH_LEN3;
            end
            PH_LEN3: begin
                n_len = len_full;
                if (len_full == '0) begin
                    push                   = 1'b1;
                    result.is_compressed   = r_comp;
                    result.last_of_message = 1'b1;
                    result.empty_message   = 1'b1;
                    n_phase                = PH_FLAG;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_len                  = r_len - 1'b1;
                push                   = 1'b1;
                result.payload_byte    = i_stream_byte;
                result.is_compressed   = r_comp;
                if (r_len == {{(lpmd_pkg::LEN_W-1){1'b0}}, 1'b1}) begin
                    result.last_of_message = 1'b1;
                    n_phase                = PH_FLAG;
                end
            end
            default: begin
                if (i_stream_byte != lpmd_pkg::FLAG_PLAIN &&
                    i_stream_byte != lpmd_pkg::FLAG_COMPRESSED) begin
                    push            = 1'b1;
                    result.bad_flag = 1'b1;
                    n_phase         = PH_FLAG;
                end else begin
                    n_comp  = i_stream_byte[0];
                    n_len   = '0;
                    n_phase = PH_LEN0;
                end
            end
        endcase
    end

    assign o_push   = accept && push;
    assign o_result = result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAG;
            r_len   <= '0;
            r_comp  <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_comp  <= n_comp;
        end
    end

endmodule

// File: rtl/lpmd_queue.sv
// ----------------------------------------------------------------------------
// lpmd_queue
// Two-entry result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module lpmd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lpmd_pkg::t_result     i_wr_data,
    input  logic                  i_pop,
    output lpmd_pkg::t_result     o_rd_data,
    output lpmd_pkg::t_q_status   o_status
);

    lpmd_pkg::t_result                r_mem [lpmd_pkg::Q_DEPTH];
    logic [lpmd_pkg::Q_PTR_W-1:0]     r_wr_ptr;
    logic [lpmd_pkg::Q_PTR_W-1:0]     r_rd_ptr;
    logic [lpmd_pkg::Q_CNT_W-1:0]     r_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_status.full  = (r_count == lpmd_pkg::Q_CNT_W'(lpmd_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_rd_data      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/lpmd_back.sv
// ----------------------------------------------------------------------------
// lpmd_back
// Output stage: moves queued results into the output register.
// ----------------------------------------------------------------------------
module lpmd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpmd_pkg::t_q_status           i_q_status,
    input  lpmd_pkg::t_result             i_q_data,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output lpmd_pkg::t_result             o_result
);

    logic               r_valid;
    lpmd_pkg::t_result  r_result;
    logic               take;

    // The output register can load when it is empty or its transfer completes.
    assign take    = !r_valid || !i_stall;
    assign o_pop   = take && !i_q_status.empty;
    assign o_valid = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= !i_q_status.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_q_data;
        end
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-prefixed message deframer. It drives
// framed byte streams (a short directed table, then random frames mixed with
// bad flag bytes) through bursty input transfers. The receiver stalls on its
// own changing pattern. Every output transfer is compared field by field with
// an in-order queue of expected results. A behavioral parser inside the bench
// fills that queue, apart from the typed rows of the directed table.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the block. Every input starts at a known
    // value, and reset is held low before the stimulus starts.
    // ------------------------------------------------------------------------
    logic                        i_clk           = 1'b0;
    logic                        i_rst_n         = 1'b0;
    logic                        i_valid         = 1'b0;
    logic [lpmd_pkg::BYTE_W-1:0] i_stream_byte   = '0;
    logic                        i_stall         = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic [lpmd_pkg::BYTE_W-1:0] o_payload_byte;
    logic                        o_is_compressed;
    logic                        o_last_of_message;
    logic                        o_empty_message;
    logic                        o_bad_flag;

    always #2 i_clk = ~i_clk;

    length_prefixed_message_deframer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_stream_byte     (i_stream_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_payload_byte    (o_payload_byte),
        .o_is_compressed   (o_is_compressed),
        .o_last_of_message (o_last_of_message),
        .o_empty_message   (o_empty_message),
        .o_bad_flag        (o_bad_flag)
    );

    // ------------------------------------------------------------------------
    // Behavioral frame parser. It keeps its own copy of the parse state and
    // tells, for one accepted stream byte, whether a result comes out and
    // what that result is.
    // ------------------------------------------------------------------------
    typedef enum logic [2:0] {
        ST_FLAG,
        ST_LEN0,
        ST_LEN1,
        ST_LEN2,
        ST_LEN3,
        ST_PAYLOAD
    } t_parse_state;

    t_parse_state               parse_state    = ST_FLAG;
    logic [lpmd_pkg::LEN_W-1:0] bytes_left     = '0;
    logic                       msg_compressed = 1'b0;

    function automatic bit deframe_byte(input logic [lpmd_pkg::BYTE_W-1:0] b,
                                        output lpmd_pkg::t_result r);
        bit produced;
        produced = 1'b0;
        r        = '0;
        case (parse_state)
            ST_LEN0: begin
                bytes_left  = {b, 24'd0};
                parse_state = ST_LEN1;
            end
            ST_LEN1: begin
                bytes_left[23:16] = b;
                parse_state       = ST_LEN2;
            end
            ST_LEN2: begin
                bytes_left[15:8] = b;
                parse_state      = ST_LEN3;
            end
            ST_LEN3: begin
                bytes_left[7:0] = b;
                if (bytes_left == '0) begin
                    // A zero-length frame closes right on its last length byte.
                    r.is_compressed   = msg_compressed;
                    r.last_of_message = 1'b1;
                    r.empty_message   = 1'b1;
                    produced          = 1'b1;
                    parse_state       = ST_FLAG;
                end else begin
                    parse_state = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD: begin
                bytes_left        = bytes_left - 1'b1;
                r.payload_byte    = b;
                r.is_compressed   = msg_compressed;
                r.last_of_message = (bytes_left == '0);
                produced          = 1'b1;
                if (bytes_left == '0) begin
                    parse_state = ST_FLAG;
                end
            end
            default: begin
                if (b > lpmd_pkg::FLAG_COMPRESSED) begin
                    // Bad flag: report it, drop the byte, keep hunting for a flag.
                    r.bad_flag = 1'b1;
                    produced   = 1'b1;
                end else begin
                    msg_compressed = b[0];
                    bytes_left     = '0;
                    parse_state    = ST_LEN0;
                end
            end
        endcase
        return produced;
    endfunction

    // Results still owed by the block, oldest first.
    lpmd_pkg::t_result expected_results[$];
    int                error_count = 0;

    task automatic note_error(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Input side. The sender works in bursts of random length and leaves
    // random gaps between them. Once valid is up it stays up, and the byte
    // is held, until the transfer goes through. The expectation is recorded
    // at the edge where the transfer is accepted. Rows of the directed table
    // that carry a typed result queue that result. Every other byte queues
    // what the parser predicts.
    // ------------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_transfer(input logic [lpmd_pkg::BYTE_W-1:0] b,
                                 input bit typed,
                                 input lpmd_pkg::t_result typed_want);
        int                gap;
        lpmd_pkg::t_result predicted;
        bit                produced;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        i_valid       <= 1'b1;
        i_stream_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
        produced = deframe_byte(b, predicted);
        if (typed) begin
            expected_results.insert(expected_results.size(), typed_want);
        end else if (produced) begin
            expected_results.insert(expected_results.size(), predicted);
        end
    endtask

    // Sends one well-formed frame with random payload content.
    task automatic send_frame(input logic [lpmd_pkg::BYTE_W-1:0] flag,
                              input logic [lpmd_pkg::LEN_W-1:0] frame_len,
                              inout int sent);
        send_transfer(flag, 1'b0, '0);
        send_transfer(frame_len[31:24], 1'b0, '0);
        send_transfer(frame_len[23:16], 1'b0, '0);
        send_transfer(frame_len[15:8], 1'b0, '0);
        send_transfer(frame_len[7:0], 1'b0, '0);
        sent += 5;
        for (int k = 0; k < frame_len; k++) begin
            send_transfer(lpmd_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
            sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table. It covers bad flags at both ends of the bad range,
    // empty plain and compressed frames, and payload bytes at their extremes.
    // The results that are plain to see are typed in. The others come from
    // the parser.
    // ------------------------------------------------------------------------
    typedef struct {
        logic [lpmd_pkg::BYTE_W-1:0] stream_byte;
        bit                          typed;
        lpmd_pkg::t_result           want;
    } t_row;

    localparam int                DIRECTED_N     = 25;
    localparam lpmd_pkg::t_result RES_NONE       = '0;
    localparam lpmd_pkg::t_result RES_BAD_FLAG   =
        lpmd_pkg::t_result'({8'h00, 1'b0, 1'b0, 1'b0, 1'b1});
    localparam lpmd_pkg::t_result RES_EMPTY      =
        lpmd_pkg::t_result'({8'h00, 1'b0, 1'b1, 1'b1, 1'b0});
    localparam lpmd_pkg::t_result RES_EMPTY_COMP =
        lpmd_pkg::t_result'({8'h00, 1'b1, 1'b1, 1'b1, 1'b0});

    t_row directed_rows [DIRECTED_N] = '{
        // Bad flag bytes straight after reset.
        '{8'hFF,                     1'b1, RES_BAD_FLAG},
        '{8'h02,                     1'b1, RES_BAD_FLAG},
        // Plain frame of length zero.
        '{lpmd_pkg::FLAG_PLAIN,      1'b0, RES_NONE},
        '{8'h00,                     1'b0, RES_NONE},
        '{8'h00,                     1'b0, RES_NONE},
        '{8'h00,                     1'b0, RES_NONE},
        '{8'h00,                     1'b1, RES_EMPTY},
        // Compressed frame of length zero.
        '{lpmd_pkg::FLAG_COMPRESSED, 1'b0, RES_NONE},
        '{8'h00,                     1'b0, RES_NONE},
        '{8'h00,                     1'b0, RES_NONE},
        '{8'h00,                     1'b0, RES_NONE},
        '{8'h00,                     1'b1, RES_EMPTY_COMP},
        // Compressed frame of two bytes, payload at both extremes.
        '{lpmd_pkg::FLAG_COMPRESSED, 1'b0, RES_NONE},
        '{8'h00,                     1'b0, RES_NONE},
        '{8'h00,                     1'b0, RES_NONE},
        '{8'h00,                     1'b0, RES_NONE},
        '{8'h02,                     1'b0, RES_NONE},
        '{8'hFF,                     1'b0, RES_NONE},
        '{8'h00,                     1'b1,
          lpmd_pkg::t_result'({8'h00, 1'b1, 1'b1, 1'b0, 1'b0})},
        // Plain frame of one byte.
        '{lpmd_pkg::FLAG_PLAIN,      1'b0, RES_NONE},
        '{8'h00,                     1'b0, RES_NONE},
        '{8'h00,                     1'b0, RES_NONE},
        '{8'h00,                     1'b0, RES_NONE},
        '{8'h01,                     1'b0, RES_NONE},
        '{8'hA5,                     1'b1,
          lpmd_pkg::t_result'({8'hA5, 1'b0, 1'b1, 1'b0, 1'b0})}
    };

    // ------------------------------------------------------------------------
    // Output side. The receiver stall follows a mode that is drawn anew at
    // random when the low bits of a tick counter wrap to zero. The modes are
    // never stalled, coin flip, mostly stalled and a fixed square wave, so the
    // queue inside the block fills and drains at every phase of a frame.
    // ------------------------------------------------------------------------
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_SQUARE
    } t_stall_mode;

    t_stall_mode stall_mode = STALL_NONE;
    logic [15:0] stall_tick = '0;

    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1'b1;
        if (stall_tick[6:0] == '0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
        end
        case (stall_mode)
            STALL_COIN:   i_stall <= ($urandom_range(0, 1) == 0);
            STALL_HEAVY:  i_stall <= ($urandom_range(0, 3) != 0);
            STALL_SQUARE: i_stall <= stall_tick[2];
            default:      i_stall <= 1'b0;
        endcase
    end

    // Every accepted output transfer must match the oldest expectation.
    lpmd_pkg::t_result seen;
    lpmd_pkg::t_result want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen = {o_payload_byte, o_is_compressed, o_last_of_message,
                    o_empty_message, o_bad_flag};
            if (expected_results.size() == 0) begin
                note_error($sformatf("result %h arrived with none expected", seen));
            end else begin
                want = expected_results.pop_front();
                if (seen.payload_byte !== want.payload_byte)
                    note_error($sformatf("payload_byte got %h want %h",
                                         seen.payload_byte, want.payload_byte));
                if (seen.is_compressed !== want.is_compressed)
                    note_error($sformatf("is_compressed got %b want %b",
                                         seen.is_compressed, want.is_compressed));
                if (seen.last_of_message !== want.last_of_message)
                    note_error($sformatf("last_of_message got %b want %b",
                                         seen.last_of_message, want.last_of_message));
                if (seen.empty_message !== want.empty_message)
                    note_error($sformatf("empty_message got %b want %b",
                                         seen.empty_message, want.empty_message));
                if (seen.bad_flag !== want.bad_flag)
                    note_error($sformatf("bad_flag got %b want %b",
                                         seen.bad_flag, want.bad_flag));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, the directed table, random traffic, and a final
    // frame that announces the largest length. The run ends partway into
    // that frame. Each payload byte gives a result, so nothing is left owed
    // when the stimulus stops.
    // ------------------------------------------------------------------------
    initial begin
        int                         sent;
        int                         drain_cycles;
        logic [lpmd_pkg::LEN_W-1:0] frame_len;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_N; r++) begin
            send_transfer(directed_rows[r].stream_byte, directed_rows[r].typed,
                          directed_rows[r].want);
        end

        // Random traffic. Most of it is well-formed frames with short
        // payloads. A few frames are empty or hold 256 bytes or more, so the
        // third length byte is nonzero. About one pick in ten is a stray
        // bad flag byte.
        sent = 0;
        while (sent < 500) begin
            if ($urandom_range(0, 9) == 0) begin
                send_transfer(lpmd_pkg::BYTE_W'($urandom_range(2, 255)), 1'b0, '0);
                sent++;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1:    frame_len = '0;
                    2:       frame_len = lpmd_pkg::LEN_W'($urandom_range(256, 300));
                    3, 4, 5: frame_len = lpmd_pkg::LEN_W'($urandom_range(17, 64));
                    default: frame_len = lpmd_pkg::LEN_W'($urandom_range(1, 16));
                endcase
                send_frame(lpmd_pkg::BYTE_W'($urandom_range(0, 1)), frame_len, sent);
            end
        end

        // All-ones length. Only the start of this payload is sent.
        send_transfer(lpmd_pkg::FLAG_COMPRESSED, 1'b0, '0);
        repeat (4) send_transfer(8'hFF, 1'b0, '0);
        repeat (16) send_transfer(lpmd_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
        i_valid <= 1'b0;

        // Let the owed results drain, then watch on for any extra result.
        drain_cycles = 0;
        while (expected_results.size() != 0 && drain_cycles < 20000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            note_error($sformatf("%0d expected results never arrived",
                                 expected_results.size()));
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Timeout: the run did not finish");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
